[hdl/vgrt_pkg.sv]
// ----------------------------------------------------------------------------
// vgrt_pkg
// Shared types and constants of the voxel grid ray walker.
// ----------------------------------------------------------------------------
package vgrt_pkg;

  // Fixed field and datapath widths
  localparam int ORIGIN_W   = 24;
  localparam int DIR_W      = 16;
  localparam int DIST_W     = 16;
  localparam int OUT_COORD_W = 16;
  localparam int T_W        = 32;
  localparam int STEPS_W    = 16;
  localparam int SUMSQ_W    = 32;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;
  localparam int S_DATA_W   = 144;
  localparam int M_DATA_W   = 104;

  // Request codes carried on s_tuser
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_ANSWER = 1'b1;

  // Result codes carried on m_tuser
  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_ROOT,
    ST_AXIS,
    ST_DDELTA,
    ST_DTMAX,
    ST_LOAD,
    ST_STEP,
    ST_STEP_END,
    ST_EMIT
  } state_t;

endpackage

[hdl/vgrt_isqrt.sv]
// ----------------------------------------------------------------------------
// vgrt_isqrt
// Bit-serial integer square root of (radicand * 2^32), two radicand bits a cycle.
// ----------------------------------------------------------------------------
module vgrt_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] nsh;
  logic [35:0] rem;
  logic [4:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem[33:0], nsh[63:62]};
    trial  = {2'b00, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= {radicand, 32'd0};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nsh  <= {nsh[61:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[30:0], ge};
    end
  end

endmodule

[hdl/vgrt_div.sv]
// ----------------------------------------------------------------------------
// vgrt_div
// Bit-serial restoring divider, one quotient bit a cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module vgrt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [vgrt_pkg::DIV_NUM_W-1:0] num,
  input  logic [vgrt_pkg::DIV_DEN_W-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [vgrt_pkg::T_W-1:0]       quot
);

  localparam int NW = vgrt_pkg::DIV_NUM_W;
  localparam int DW = vgrt_pkg::DIV_DEN_W;
  localparam int TW = vgrt_pkg::T_W;

  logic [NW-1:0] nsh;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [5:0]    cnt;
  logic [DW:0]   trial;
  logic          ge;

  // Bring down one numerator bit and compare
  always_comb begin
    trial = {rem, nsh[NW-1]};
    ge    = (trial >= {1'b0, dreg});
  end

  // Saturate a quotient that does not fit
  assign quot = (|quo[NW-1:TW]) ? {TW{1'b1}} : quo[TW-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      nsh <= {nsh[NW-2:0], 1'b0};
      rem <= ge ? DW'(trial - {1'b0, dreg}) : DW'(trial);
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

[hdl/voxel_grid_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// Walks a ray through a voxel grid, one query, hit or miss result per transaction.
// ----------------------------------------------------------------------------
// An answer transaction passes through the step, the end check and the output
// load, a hit skipping the end check; the output load waits while a held result
// is not taken. A start transaction waits on the bit-serial square root and the
// bit-serial divider, which runs twice per axis with a nonzero direction; a zero
// direction or distance skips both units and gives a miss.
// Reset (rst, synchronous) clears the ray state to zero and leaves it idle.
module voxel_grid_ray_traversal #(
  parameter int VOXEL_COORD_BITS = 16,
  parameter int T_FRAC_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, voxel_solid
  input  logic [vgrt_pkg::S_DATA_W-1:0] s_tdata,
  // req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // voxel_x/y/z, prev_x/y/z, normal_x/y/z
  output logic [vgrt_pkg::M_DATA_W-1:0] m_tdata,
  // result_kind
  output logic [1:0]                    m_tuser
);

  localparam int VB = VOXEL_COORD_BITS;
  localparam int TW = vgrt_pkg::T_W;
  localparam int DEN_SHIFT = 24 - T_FRAC_BITS;
  localparam logic [TW-1:0] T_EPS = TW'((64'd1 << T_FRAC_BITS) / 10000);
  localparam logic [TW-1:0] T_SAT = {TW{1'b1}};

  vgrt_pkg::state_t state, state_next;
  vgrt_pkg::kind_t  res_kind;

  // Captured request fields (max distance only from a start)
  logic [vgrt_pkg::ORIGIN_W-1:0] org [3];
  logic [vgrt_pkg::DIR_W-1:0]    dir [3];
  logic [vgrt_pkg::DIST_W-1:0]   maxd;
  logic                          solid;

  // Ray state
  logic [VB-1:0]                 cur_voxel [3];
  logic [VB-1:0]                 prev_voxel [3];
  logic signed [1:0]             step_sign [3];
  logic signed [1:0]             last_normal [3];
  logic [TW-1:0]                 t_max [3];
  logic [TW-1:0]                 t_delta [3];
  logic [TW-1:0]                 t_now;
  logic [TW-1:0]                 t_limit;
  logic [vgrt_pkg::STEPS_W-1:0]  steps_left;
  logic                          ray_active;

  logic [1:0]                    ax;
  logic [vgrt_pkg::SUMSQ_W-1:0]  sumsq;
  logic [31:0]                   len;

  // Shared arithmetic units
  logic        root_start, root_busy, root_done;
  logic [31:0] root_val;
  logic        div_start, div_busy, div_done;
  logic [vgrt_pkg::DIV_NUM_W-1:0] div_num;
  logic [vgrt_pkg::DIV_DEN_W-1:0] div_den;
  logic [TW-1:0] div_quot;
  logic        out_load;
  logic [vgrt_pkg::M_DATA_W-1:0] m_tdata_next;

  logic [vgrt_pkg::DIR_W-1:0]    mag;
  logic [8:0]                    bdist;
  logic signed [31:0]            sq;
  logic                          start_zero;
  logic [1:0]                    sel;
  logic [TW:0]                   tsum;

  vgrt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sumsq),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root_val)
  );

  vgrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Per-axis helpers for the axis under setup
  always_comb begin
    mag   = dir[ax][vgrt_pkg::DIR_W-1] ? vgrt_pkg::DIR_W'(-dir[ax]) : dir[ax];
    bdist = dir[ax][vgrt_pkg::DIR_W-1] ? {1'b0, org[ax][7:0]}
                                       : (9'd256 - {1'b0, org[ax][7:0]});
    sq    = $signed(dir[ax]) * $signed(dir[ax]);
    start_zero = (sumsq == '0) || (maxd == '0);
    div_den = vgrt_pkg::DIV_DEN_W'(mag) << DEN_SHIFT;
    div_num = (state == vgrt_pkg::ST_AXIS)
              ? vgrt_pkg::DIV_NUM_W'({len, 8'd0})
              : vgrt_pkg::DIV_NUM_W'(bdist) * vgrt_pkg::DIV_NUM_W'(len);
  end

  // Pick the axis with the nearest boundary
  always_comb begin
    if (t_max[0] < t_max[1]) begin
      sel = (t_max[0] < t_max[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (t_max[1] < t_max[2]) ? 2'd1 : 2'd2;
    end
    tsum = {1'b0, t_max[sel]} + {1'b0, t_delta[sel]};
  end

  assign s_tready = (state == vgrt_pkg::ST_IDLE) && !rst;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vgrt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == vgrt_pkg::REQ_START) begin
            state_next = vgrt_pkg::ST_SQUARE;
          end else if (!ray_active) begin
            state_next = vgrt_pkg::ST_EMIT;
          end else begin
            state_next = vgrt_pkg::ST_STEP;
          end
        end
      end
      vgrt_pkg::ST_SQUARE: begin
        if (ax == 2'd2) state_next = vgrt_pkg::ST_CHECK;
      end
      vgrt_pkg::ST_CHECK: begin
        state_next = start_zero ? vgrt_pkg::ST_EMIT : vgrt_pkg::ST_ROOT;
      end
      vgrt_pkg::ST_ROOT: begin
        if (root_done) state_next = vgrt_pkg::ST_AXIS;
      end
      vgrt_pkg::ST_AXIS: begin
        if (dir[ax] != '0) begin
          state_next = vgrt_pkg::ST_DDELTA;
        end else if (ax == 2'd2) begin
          state_next = vgrt_pkg::ST_LOAD;
        end
      end
      vgrt_pkg::ST_DDELTA: begin
        if (div_done) state_next = vgrt_pkg::ST_DTMAX;
      end
      vgrt_pkg::ST_DTMAX: begin
        if (div_done) begin
          state_next = (ax == 2'd2) ? vgrt_pkg::ST_LOAD : vgrt_pkg::ST_AXIS;
        end
      end
      vgrt_pkg::ST_LOAD:     state_next = vgrt_pkg::ST_EMIT;
      vgrt_pkg::ST_STEP: begin
        state_next = (solid && t_now > T_EPS) ? vgrt_pkg::ST_EMIT
                                              : vgrt_pkg::ST_STEP_END;
      end
      vgrt_pkg::ST_STEP_END: state_next = vgrt_pkg::ST_EMIT;
      vgrt_pkg::ST_EMIT: begin
        if (out_load) state_next = vgrt_pkg::ST_IDLE;
      end
      default:               state_next = vgrt_pkg::ST_IDLE;
    endcase
  end

  // Unit launches and output load
  always_comb begin
    root_start = (state == vgrt_pkg::ST_CHECK) && !start_zero;
    div_start  = ((state == vgrt_pkg::ST_AXIS) && (dir[ax] != '0)) ||
                 ((state == vgrt_pkg::ST_DDELTA) && div_done);
    out_load   = (state == vgrt_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  end

  // Result payload: zero on a miss, previous voxel and normal only on a hit
  always_comb begin
    m_tdata_next = '0;
    if (res_kind != vgrt_pkg::KIND_MISS) begin
      m_tdata_next[15:0]  = 16'(cur_voxel[0]);
      m_tdata_next[31:16] = 16'(cur_voxel[1]);
      m_tdata_next[47:32] = 16'(cur_voxel[2]);
    end
    if (res_kind == vgrt_pkg::KIND_HIT) begin
      m_tdata_next[63:48]   = 16'(prev_voxel[0]);
      m_tdata_next[79:64]   = 16'(prev_voxel[1]);
      m_tdata_next[95:80]   = 16'(prev_voxel[2]);
      m_tdata_next[97:96]   = last_normal[0];
      m_tdata_next[99:98]   = last_normal[1];
      m_tdata_next[101:100] = last_normal[2];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vgrt_pkg::ST_IDLE;
      ray_active <= 1'b0;
      m_tvalid   <= 1'b0;
      ax         <= '0;
      res_kind   <= vgrt_pkg::KIND_MISS;
      steps_left <= '0;
      t_now      <= '0;
      t_limit    <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_voxel[i]   <= '0;
        prev_voxel[i]  <= '0;
        step_sign[i]   <= '0;
        last_normal[i] <= '0;
        t_max[i]       <= '0;
        t_delta[i]     <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        vgrt_pkg::ST_IDLE: begin
          ax <= '0;
          if (s_tvalid) begin
            if (s_tuser == vgrt_pkg::REQ_START) begin
              ray_active <= 1'b0;
            end else if (!ray_active) begin
              res_kind <= vgrt_pkg::KIND_MISS;
            end
          end
        end
        vgrt_pkg::ST_SQUARE: begin
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        vgrt_pkg::ST_CHECK: begin
          res_kind <= vgrt_pkg::KIND_MISS;
        end
        vgrt_pkg::ST_ROOT: ;
        vgrt_pkg::ST_AXIS: begin
          if (dir[ax] == '0) begin
            step_sign[ax] <= '0;
            t_max[ax]     <= T_SAT;
            t_delta[ax]   <= T_SAT;
            ax            <= ax + 2'd1;
          end else begin
            step_sign[ax] <= dir[ax][vgrt_pkg::DIR_W-1] ? -2'sd1 : 2'sd1;
          end
        end
        vgrt_pkg::ST_DDELTA: begin
          if (div_done) t_delta[ax] <= div_quot;
        end
        vgrt_pkg::ST_DTMAX: begin
          if (div_done) begin
            t_max[ax] <= div_quot;
            ax        <= ax + 2'd1;
          end
        end
        vgrt_pkg::ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            cur_voxel[i]   <= VB'($signed(org[i][23:8]));
            prev_voxel[i]  <= VB'($signed(org[i][23:8]));
            last_normal[i] <= '0;
          end
          t_now      <= '0;
          t_limit    <= TW'(maxd) << (T_FRAC_BITS - 8);
          steps_left <= vgrt_pkg::STEPS_W'(((18'(maxd) * 18'd3) >> 8) + 18'd3);
          ray_active <= 1'b1;
          res_kind   <= vgrt_pkg::KIND_QUERY;
        end
        vgrt_pkg::ST_STEP: begin
          if (solid && t_now > T_EPS) begin
            ray_active <= 1'b0;
            res_kind   <= vgrt_pkg::KIND_HIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              prev_voxel[i]  <= cur_voxel[i];
              last_normal[i] <= (sel == 2'(i)) ? -step_sign[i] : 2'sd0;
            end
            t_now          <= t_max[sel];
            cur_voxel[sel] <= cur_voxel[sel] + VB'(step_sign[sel]);
            t_max[sel]     <= tsum[TW] ? T_SAT : tsum[TW-1:0];
            steps_left     <= steps_left - vgrt_pkg::STEPS_W'(1);
          end
        end
        vgrt_pkg::ST_STEP_END: begin
          if (steps_left == '0 || t_now > t_limit) begin
            ray_active <= 1'b0;
            res_kind   <= vgrt_pkg::KIND_MISS;
          end else begin
            res_kind   <= vgrt_pkg::KIND_QUERY;
          end
        end
        vgrt_pkg::ST_EMIT: ;
        default: ;
      endcase
    end
  end

  // Payload registers: capture fields, sum of squares, root, output
  always_ff @(posedge clk) begin
    if (state == vgrt_pkg::ST_IDLE && s_tvalid) begin
      org[0] <= s_tdata[23:0];
      org[1] <= s_tdata[47:24];
      org[2] <= s_tdata[71:48];
      dir[0] <= s_tdata[87:72];
      dir[1] <= s_tdata[103:88];
      dir[2] <= s_tdata[119:104];
      if (s_tuser == vgrt_pkg::REQ_START) maxd <= s_tdata[135:120];
      solid  <= s_tdata[136];
      sumsq  <= '0;
    end else if (state == vgrt_pkg::ST_SQUARE) begin
      sumsq <= sumsq + vgrt_pkg::SUMSQ_W'($unsigned(sq));
    end
    if (root_done) len <= root_val;
    if (out_load) begin
      m_tuser <= res_kind;
      m_tdata <= m_tdata_next;
    end
  end

  // The two iterative units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(root_busy && div_busy)) else $error("root and divider both busy");

  // A query is only issued for a live ray
  a_query_active: assert property (@(posedge clk) disable iff (rst)
    (state == vgrt_pkg::ST_EMIT && res_kind == vgrt_pkg::KIND_QUERY) |-> ray_active)
    else $error("query issued with no active ray");

  // A hit always carries a crossed face
  a_hit_normal: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_kind == vgrt_pkg::KIND_HIT) |->
    (last_normal[0] != 2'sd0 || last_normal[1] != 2'sd0 || last_normal[2] != 2'sd0))
    else $error("hit without face normal");

  // A hit or miss ends the ray
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_kind != vgrt_pkg::KIND_QUERY) |-> !ray_active)
    else $error("ray still active after final result");

endmodule
